@@ hdl/gkb_pkg.sv @@
// Shared types and constants for the grid keypoint bucketing block.
package gkb_pkg;

   // Input field widths.
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned COORD_W = 11;
   localparam int unsigned SCORE_W = 8;
   localparam int unsigned GRID_W  = 6;
   localparam int unsigned ID_W    = 64;
   localparam int unsigned DIM_W   = 12;

   // Default sizes of the grid storage.
   localparam int unsigned DEF_MAX_GRID_ROWS  = 64;
   localparam int unsigned DEF_MAX_GRID_COLS  = 64;
   localparam int unsigned DEF_CELL_SIZE_LOG2 = 5;

   // Register reset values.
   localparam logic [DIM_W-1:0] RESET_IMAGE_WIDTH  = 12'd640;
   localparam logic [DIM_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;

   // Register select, taken from paddr bit 2.
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // Command codes.
   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_MARK  = 2'd0;
   localparam cmd_type CMD_CAND  = 2'd1;
   localparam cmd_type CMD_DRAIN = 2'd2;

   typedef enum logic [1:0] {
      ST_EMPTY = 2'd0,
      ST_CAND  = 2'd1,
      ST_OCC   = 2'd2
   } status_type;

   // One grid entry as it is kept in the table.
   typedef struct packed {
      status_type          status;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [SCORE_W-1:0]  score;
   } cell_type;

   localparam int unsigned CELL_W = $bits(cell_type);

endpackage

@@ hdl/gkb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gkb_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address written in the same cycle returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/grid_keypoint_bucketing.sv @@
// Grid keypoint bucketing: one strongest corner per free grid cell.
//
// Items enter on the command channel: an item is taken at a clock edge where
// start is high and busy is low. A mark item flags the cell under a tracked
// point as occupied, a candidate item offers a corner to its cell (clamped to
// the last grid row and column), and a drain item reads one cell, returns
// its corner with a new feature id if it holds one, and empties it.
// Every item gives exactly one result, shown for one cycle with rsp_valid.
// The result of an item passes through the item register and the result
// register to the rsp_ ports. A new item can be taken at every edge while
// busy is low: one table read at acceptance, one write at the next edge,
// with the last write forwarded to the item that follows it.
// The receiver has no way to hold results off; it must take each one.
// After reset the table is swept clear one entry a cycle, over all
// MAX_GRID_ROWS * MAX_GRID_COLS entries (4096 by default); busy is high
// during the sweep. Image size registers sit on the APB port at byte
// addresses 0 (width) and 4 (height); the user must write them only while
// idle, and the block itself does not enforce it.
module grid_keypoint_bucketing #(
   parameter int unsigned MAX_GRID_ROWS  = gkb_pkg::DEF_MAX_GRID_ROWS,
   parameter int unsigned MAX_GRID_COLS  = gkb_pkg::DEF_MAX_GRID_COLS,
   parameter int unsigned CELL_SIZE_LOG2 = gkb_pkg::DEF_CELL_SIZE_LOG2
) (
   input  logic                          clock,
   input  logic                          reset,
   // Command channel
   input  logic                          start,
   output logic                          busy,
   input  gkb_pkg::cmd_type              req_cmd,
   input  logic [gkb_pkg::COORD_W-1:0]   req_pos_x,
   input  logic [gkb_pkg::COORD_W-1:0]   req_pos_y,
   input  logic [gkb_pkg::SCORE_W-1:0]   req_score,
   input  logic [gkb_pkg::GRID_W-1:0]    req_cell_row,
   input  logic [gkb_pkg::GRID_W-1:0]    req_cell_col,
   // Result channel
   output logic                          rsp_valid,
   output logic                          rsp_has_point,
   output logic [gkb_pkg::COORD_W-1:0]   rsp_point_x,
   output logic [gkb_pkg::COORD_W-1:0]   rsp_point_y,
   output logic [gkb_pkg::ID_W-1:0]      rsp_feature_id,
   // Configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   import gkb_pkg::*;

   localparam int unsigned DEPTH = MAX_GRID_ROWS * MAX_GRID_COLS;
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned RI_W  = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
   localparam int unsigned CI_W  = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
   localparam int unsigned GR_W  = $clog2(MAX_GRID_ROWS + 1);
   localparam int unsigned GC_W  = $clog2(MAX_GRID_COLS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   // Cells covering len pixels, limited to 1..limit.
   function automatic logic [12:0] grid_count(input logic [DIM_W-1:0] len,
                                              input int unsigned limit);
      logic [12:0] n;
      n = (13'(len) + 13'((1 << CELL_SIZE_LOG2) - 1)) >> CELL_SIZE_LOG2;
      if (n == 13'd0) begin
         n = 13'd1;
      end
      if (32'(n) > limit) begin
         n = 13'(limit);
      end
      return n;
   endfunction

   // Configuration registers and the grid size derived from them.
   logic [DIM_W-1:0] image_width_ff;
   logic [DIM_W-1:0] image_height_ff;
   logic [GR_W-1:0]  grid_rows_ff;
   logic [GC_W-1:0]  grid_cols_ff;
   logic             cfg_write;

   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RESET_IMAGE_WIDTH;
         image_height_ff <= RESET_IMAGE_HEIGHT;
         grid_cols_ff    <= GC_W'(grid_count(RESET_IMAGE_WIDTH, MAX_GRID_COLS));
         grid_rows_ff    <= GR_W'(grid_count(RESET_IMAGE_HEIGHT, MAX_GRID_ROWS));
      end else if (cfg_write) begin
         if (paddr[2] == REG_IMAGE_WIDTH) begin
            image_width_ff <= pwdata[DIM_W-1:0];
            grid_cols_ff   <= GC_W'(grid_count(pwdata[DIM_W-1:0], MAX_GRID_COLS));
         end else begin
            image_height_ff <= pwdata[DIM_W-1:0];
            grid_rows_ff    <= GR_W'(grid_count(pwdata[DIM_W-1:0], MAX_GRID_ROWS));
         end
      end
   end

   assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? 32'(image_height_ff)
                                                  : 32'(image_width_ff);

   // Clearing sweep after reset.
   logic             clearing_ff;
   logic [IDX_W-1:0] clear_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
      end else if (clearing_ff) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
         if (clear_idx_ff == LAST_IDX) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   assign busy = clearing_ff;

   // Acceptance: find the cell the item refers to.
   logic                accept;
   logic [COORD_W-1:0]  gi_full;
   logic [COORD_W-1:0]  gj_full;
   logic                row_in_grid;
   logic                col_in_grid;
   logic                drain_in_store;
   logic [RI_W-1:0]     sel_row;
   logic [CI_W-1:0]     sel_col;
   logic                sel_act;
   logic [IDX_W-1:0]    sel_idx;

   assign accept  = start && !busy;
   assign gi_full = req_pos_y >> CELL_SIZE_LOG2;
   assign gj_full = req_pos_x >> CELL_SIZE_LOG2;
   assign row_in_grid = 12'(gi_full) < 12'(grid_rows_ff);
   assign col_in_grid = 12'(gj_full) < 12'(grid_cols_ff);
   assign drain_in_store = (32'(req_cell_row) < MAX_GRID_ROWS) &&
                           (32'(req_cell_col) < MAX_GRID_COLS);

   always_comb begin
      sel_row = RI_W'(gi_full);
      sel_col = CI_W'(gj_full);
      sel_act = 1'b0;
      unique case (req_cmd)
         CMD_MARK: begin
            sel_act = row_in_grid && col_in_grid;
         end
         CMD_CAND: begin
            if (!row_in_grid) begin
               sel_row = RI_W'(grid_rows_ff - 1'b1);
            end
            if (!col_in_grid) begin
               sel_col = CI_W'(grid_cols_ff - 1'b1);
            end
            sel_act = 1'b1;
         end
         CMD_DRAIN: begin
            sel_row = RI_W'(req_cell_row);
            sel_col = CI_W'(req_cell_col);
            sel_act = drain_in_store;
         end
         default: begin
            sel_act = 1'b0;
         end
      endcase
   end

   assign sel_idx = IDX_W'(sel_row) * IDX_W'(MAX_GRID_COLS) + IDX_W'(sel_col);

   // Item register; the table read runs alongside it.
   logic                s1_valid_ff;
   cmd_type             s1_cmd_ff;
   logic                s1_act_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [COORD_W-1:0]  s1_x_ff;
   logic [COORD_W-1:0]  s1_y_ff;
   logic [SCORE_W-1:0]  s1_score_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff   <= req_cmd;
         s1_act_ff   <= sel_act;
         s1_idx_ff   <= sel_idx;
         s1_x_ff     <= req_pos_x;
         s1_y_ff     <= req_pos_y;
         s1_score_ff <= req_score;
      end
   end

   // Table and write-back forwarding.
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic [CELL_W-1:0] ram_rdata;

   logic              wr_valid_ff;
   logic [IDX_W-1:0]  wr_idx_ff;
   cell_type          wr_data_ff;

   cell_type          cur;
   cell_type          upd_data;
   logic              upd_we;
   logic              hit;

   gkb_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (sel_idx),
      .rd_data (ram_rdata)
   );

   // The previous item's write lands in the same edge as this item's read,
   // so its data is taken from the forwarding register instead.
   always_comb begin
      if (wr_valid_ff && (wr_idx_ff == s1_idx_ff)) begin
         cur = wr_data_ff;
      end else begin
         cur = cell_type'(ram_rdata);
      end
   end

   always_comb begin
      upd_we   = 1'b0;
      upd_data = cur;
      hit      = 1'b0;
      if (s1_valid_ff && s1_act_ff) begin
         unique case (s1_cmd_ff)
            CMD_MARK: begin
               upd_we          = 1'b1;
               upd_data.status = ST_OCC;
            end
            CMD_CAND: begin
               if ((cur.status == ST_EMPTY) ||
                   ((cur.status == ST_CAND) && (s1_score_ff > cur.score))) begin
                  upd_we         = 1'b1;
                  upd_data.status = ST_CAND;
                  upd_data.x     = s1_x_ff;
                  upd_data.y     = s1_y_ff;
                  upd_data.score = s1_score_ff;
               end
            end
            CMD_DRAIN: begin
               upd_we          = 1'b1;
               upd_data.status = ST_EMPTY;
               hit             = (cur.status == ST_CAND);
            end
            default: begin
               upd_we = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      if (clearing_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clear_idx_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = upd_we;
         ram_waddr = s1_idx_ff;
         ram_wdata = upd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else begin
         wr_valid_ff <= upd_we;
      end
   end

   always_ff @(posedge clock) begin
      wr_idx_ff  <= s1_idx_ff;
      wr_data_ff <= upd_data;
   end

   // Result register and feature id counter.
   logic               rsp_valid_ff;
   logic               rsp_has_point_ff;
   logic [COORD_W-1:0] rsp_point_x_ff;
   logic [COORD_W-1:0] rsp_point_y_ff;
   logic [ID_W-1:0]    rsp_feature_id_ff;
   logic [ID_W-1:0]    next_id_ff;
   logic [ID_W-1:0]    next_id_in;

   assign next_id_in = next_id_ff + ID_W'(hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         next_id_ff   <= '0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
         next_id_ff   <= next_id_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_has_point_ff  <= hit;
      rsp_point_x_ff    <= hit ? cur.x : '0;
      rsp_point_y_ff    <= hit ? cur.y : '0;
      rsp_feature_id_ff <= hit ? next_id_ff : '0;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_has_point  = rsp_has_point_ff;
   assign rsp_point_x    = rsp_point_x_ff;
   assign rsp_point_y    = rsp_point_y_ff;
   assign rsp_feature_id = rsp_feature_id_ff;

endmodule
